### hw/rtl/rpn_stack_calculator_unit_macros.svh
// assertion helpers for the rpn stack calculator
`ifndef RPN_STACK_CALCULATOR_UNIT_MACROS_SVH
`define RPN_STACK_CALCULATOR_UNIT_MACROS_SVH

// same-cycle implication
`define RPN_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("rpn stack calculator: same-cycle check failed");

// next-cycle implication
`define RPN_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("rpn stack calculator: next-cycle check failed");

`endif

### hw/rtl/rpncalc_pkg.sv
package rpncalc_pkg;

   localparam int WORD_W          = 32;
   localparam int DEPTH_W         = 5;
   localparam int KIND_W          = 3;
   localparam int STATUS_W        = 3;
   localparam int STEP_W          = $clog2(WORD_W);
   localparam int STACK_DEPTH_DEF = 16;

   // token codes
   localparam logic [KIND_W-1:0] REQ_PUSH = 3'd0;
   localparam logic [KIND_W-1:0] REQ_ADD  = 3'd1;
   localparam logic [KIND_W-1:0] REQ_SUB  = 3'd2;
   localparam logic [KIND_W-1:0] REQ_MUL  = 3'd3;
   localparam logic [KIND_W-1:0] REQ_DIV  = 3'd4;
   localparam logic [KIND_W-1:0] REQ_POP  = 3'd5;

   // result status codes
   localparam logic [STATUS_W-1:0] ST_OK       = 3'd0;
   localparam logic [STATUS_W-1:0] ST_OVERFLOW = 3'd1;
   localparam logic [STATUS_W-1:0] ST_UNDER    = 3'd2;
   localparam logic [STATUS_W-1:0] ST_DIV_ZERO = 3'd3;
   localparam logic [STATUS_W-1:0] ST_HALTED   = 3'd4;

   typedef struct packed {
      logic [KIND_W-1:0]        req_type;
      logic signed [WORD_W-1:0] operand_value;
   } req_item_type;

   typedef struct packed {
      logic signed [WORD_W-1:0] value;
      logic [DEPTH_W-1:0]       depth;
      logic [STATUS_W-1:0]      status;
   } rsp_item_type;

   typedef enum logic [1:0] {
      ALU_ADD,
      ALU_SUB,
      ALU_MUL,
      ALU_DIV
   } alu_op_type;

   typedef struct packed {
      logic              start;
      alu_op_type        op;
      logic [WORD_W-1:0] a;
      logic [WORD_W-1:0] b;
   } alu_req_type;

   typedef struct packed {
      logic              done;
      logic [WORD_W-1:0] result;
   } alu_rsp_type;

   typedef enum logic [1:0] {
      ALU_IDLE,
      ALU_RUN,
      ALU_FIX
   } alu_state_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_DISPATCH,
      S_POP_WAIT,
      S_POP_A,
      S_LOAD_A,
      S_EXEC
   } ctl_state_type;

endpackage

### hw/rtl/rpncalc_alu.sv
module rpncalc_alu (
   input  logic                      clock,
   input  logic                      reset,
   input  rpncalc_pkg::alu_req_type  alu_req,
   output rpncalc_pkg::alu_rsp_type  alu_rsp
);
   import rpncalc_pkg::*;

   alu_state_type     state_ff, state_in;
   logic [WORD_W-1:0] rem_ff, rem_in;
   logic [WORD_W-1:0] quo_ff, quo_in;
   logic [WORD_W-1:0] dvsr_ff, dvsr_in;
   logic              neg_ff, neg_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic [WORD_W-1:0] result_ff, result_in;
   logic              done_ff, done_in;

   logic [WORD_W-1:0] abs_a, abs_b;
   logic [WORD_W:0]   shifted, trial;

   assign abs_a   = alu_req.a[WORD_W-1] ? (~alu_req.a + 1'b1) : alu_req.a;
   assign abs_b   = alu_req.b[WORD_W-1] ? (~alu_req.b + 1'b1) : alu_req.b;
   // one restoring step: bring down the next dividend bit, try the subtract
   assign shifted = {rem_ff, quo_ff[WORD_W-1]};
   assign trial   = shifted - {1'b0, dvsr_ff};

   always_comb begin
      state_in  = state_ff;
      rem_in    = rem_ff;
      quo_in    = quo_ff;
      dvsr_in   = dvsr_ff;
      neg_in    = neg_ff;
      step_in   = step_ff;
      result_in = result_ff;
      done_in   = 1'b0;
      unique case (state_ff)
         ALU_IDLE: begin
            if (alu_req.start) begin
               unique case (alu_req.op)
                  ALU_ADD: begin
                     result_in = alu_req.a + alu_req.b;
                     done_in   = 1'b1;
                  end
                  ALU_SUB: begin
                     result_in = alu_req.a - alu_req.b;
                     done_in   = 1'b1;
                  end
                  ALU_MUL: begin
                     result_in = alu_req.a * alu_req.b;
                     done_in   = 1'b1;
                  end
                  ALU_DIV: begin
                     rem_in   = '0;
                     quo_in   = abs_a;
                     dvsr_in  = abs_b;
                     neg_in   = alu_req.a[WORD_W-1] ^ alu_req.b[WORD_W-1];
                     step_in  = '0;
                     state_in = ALU_RUN;
                  end
                  default: ;
               endcase
            end
         end
         ALU_RUN: begin
            if (!trial[WORD_W]) begin
               rem_in = trial[WORD_W-1:0];
               quo_in = {quo_ff[WORD_W-2:0], 1'b1};
            end else begin
               rem_in = shifted[WORD_W-1:0];
               quo_in = {quo_ff[WORD_W-2:0], 1'b0};
            end
            step_in = step_ff + 1'b1;
            if (step_ff == STEP_W'(WORD_W - 1)) begin
               state_in = ALU_FIX;
            end
         end
         ALU_FIX: begin
            // minimum over minus one falls out as minimum here
            result_in = neg_ff ? (~quo_ff + 1'b1) : quo_ff;
            done_in   = 1'b1;
            state_in  = ALU_IDLE;
         end
         default: state_in = ALU_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ALU_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
      rem_ff    <= rem_in;
      quo_ff    <= quo_in;
      dvsr_ff   <= dvsr_in;
      neg_ff    <= neg_in;
      step_ff   <= step_in;
      result_ff <= result_in;
   end

   assign alu_rsp.done   = done_ff;
   assign alu_rsp.result = result_ff;

endmodule

### hw/rtl/rpn_stack_calculator_unit.sv
// channel    ports                              direction  handshake
// request    start, busy, req_item              in         taken when start and not busy
// response   rsp_strobe, rsp_item               out        one-cycle strobe, no back-pressure
//
// push, final pop, halted and unused tokens: answered without the alu; pop waits for the registered read.
// add, sub, mult: two stack reads, then the shared alu.
// div: the same path, through the one-bit-per-cycle divider in the alu.
// stack memory is one write and one registered read port; no clearing pass.
// synchronous reset empties the stack count and clears the halt flag.
// results cannot be stalled; busy is high from acceptance until the strobe.
`include "rpn_stack_calculator_unit_macros.svh"

module rpn_stack_calculator_unit #(
   parameter int STACK_DEPTH = rpncalc_pkg::STACK_DEPTH_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   output logic                       busy,
   input  rpncalc_pkg::req_item_type  req_item,
   output logic                       rsp_strobe,
   output rpncalc_pkg::rsp_item_type  rsp_item
);
   import rpncalc_pkg::*;

   localparam int CW = $clog2(STACK_DEPTH + 1);
   localparam int AW = $clog2(STACK_DEPTH);
   localparam logic [CW-1:0] FULL_COUNT = CW'(STACK_DEPTH);

   logic [WORD_W-1:0] stack_mem [STACK_DEPTH];
   logic [WORD_W-1:0] rd_data_ff;

   ctl_state_type     state_ff, state_in;
   logic [CW-1:0]     count_ff, count_in;
   logic              halted_ff, halted_in;
   req_item_type      req_ff, req_in;
   logic [WORD_W-1:0] b_ff, b_in;
   logic              pop_ok_ff, pop_ok_in;
   logic              under_ff, under_in;
   logic              rsp_strobe_ff, rsp_strobe_in;
   rsp_item_type      rsp_ff, rsp_in;

   logic              wr_en;
   logic [WORD_W-1:0] wr_data;
   logic [AW-1:0]     wr_addr, rd_addr;
   logic [CW-1:0]     count_dec;
   logic [WORD_W-1:0] a_word;
   alu_req_type       alu_req;
   alu_rsp_type       alu_rsp;

   assign count_dec = count_ff - 1'b1;
   // every read is of the current top of stack
   assign rd_addr   = count_dec[AW-1:0];
   assign wr_addr   = count_ff[AW-1:0];
   assign a_word    = pop_ok_ff ? rd_data_ff : '1;
   assign busy      = (state_ff != S_IDLE);

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      halted_in     = halted_ff;
      req_in        = req_ff;
      b_in          = b_ff;
      pop_ok_in     = pop_ok_ff;
      under_in      = under_ff;
      rsp_strobe_in = 1'b0;
      rsp_in        = rsp_ff;
      wr_en         = 1'b0;
      wr_data       = req_ff.operand_value;
      alu_req.start = 1'b0;
      alu_req.a     = a_word;
      alu_req.b     = b_ff;
      unique case (req_ff.req_type)
         REQ_ADD: alu_req.op = ALU_ADD;
         REQ_SUB: alu_req.op = ALU_SUB;
         REQ_MUL: alu_req.op = ALU_MUL;
         default: alu_req.op = ALU_DIV;
      endcase

      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               req_in   = req_item;
               state_in = S_DISPATCH;
            end
         end
         S_DISPATCH: begin
            if (halted_ff) begin
               rsp_in.value  = '0;
               rsp_in.status = ST_HALTED;
               rsp_strobe_in = 1'b1;
               state_in      = S_IDLE;
            end else begin
               unique case (req_ff.req_type)
                  REQ_PUSH: begin
                     rsp_in.value = req_ff.operand_value;
                     if (count_ff != FULL_COUNT) begin
                        wr_en         = 1'b1;
                        count_in      = count_ff + 1'b1;
                        rsp_in.status = ST_OK;
                     end else begin
                        rsp_in.status = ST_OVERFLOW;
                     end
                     rsp_strobe_in = 1'b1;
                     state_in      = S_IDLE;
                  end
                  REQ_ADD, REQ_SUB, REQ_MUL, REQ_DIV: begin
                     // pop b
                     pop_ok_in = (count_ff != '0);
                     under_in  = (count_ff == '0);
                     if (count_ff != '0) begin
                        count_in = count_dec;
                     end
                     state_in = S_POP_A;
                  end
                  REQ_POP: begin
                     if (count_ff != '0) begin
                        count_in = count_dec;
                        state_in = S_POP_WAIT;
                     end else begin
                        rsp_in.value  = '1;
                        rsp_in.status = ST_UNDER;
                        rsp_strobe_in = 1'b1;
                        state_in      = S_IDLE;
                     end
                  end
                  default: begin
                     rsp_in.value  = '0;
                     rsp_in.status = ST_OK;
                     rsp_strobe_in = 1'b1;
                     state_in      = S_IDLE;
                  end
               endcase
            end
         end
         S_POP_WAIT: begin
            rsp_in.value  = rd_data_ff;
            rsp_in.status = ST_OK;
            rsp_strobe_in = 1'b1;
            state_in      = S_IDLE;
         end
         S_POP_A: begin
            b_in      = pop_ok_ff ? rd_data_ff : '1;
            pop_ok_in = (count_ff != '0);
            if (count_ff != '0) begin
               count_in = count_dec;
            end else begin
               under_in = 1'b1;
            end
            state_in = S_LOAD_A;
         end
         S_LOAD_A: begin
            if (req_ff.req_type == REQ_DIV && b_ff == '0) begin
               halted_in     = 1'b1;
               rsp_in.value  = '0;
               rsp_in.status = ST_DIV_ZERO;
               rsp_strobe_in = 1'b1;
               state_in      = S_IDLE;
            end else begin
               alu_req.start = 1'b1;
               state_in      = S_EXEC;
            end
         end
         S_EXEC: begin
            if (alu_rsp.done) begin
               wr_data      = alu_rsp.result;
               rsp_in.value = alu_rsp.result;
               if (count_ff != FULL_COUNT) begin
                  wr_en    = 1'b1;
                  count_in = count_ff + 1'b1;
               end
               priority if (under_ff) begin
                  rsp_in.status = ST_UNDER;
               end else if (count_ff == FULL_COUNT) begin
                  rsp_in.status = ST_OVERFLOW;
               end else begin
                  rsp_in.status = ST_OK;
               end
               rsp_strobe_in = 1'b1;
               state_in      = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase

      rsp_in.depth = DEPTH_W'(count_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         count_ff      <= '0;
         halted_ff     <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         halted_ff     <= halted_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
      req_ff    <= req_in;
      b_ff      <= b_in;
      pop_ok_ff <= pop_ok_in;
      under_ff  <= under_in;
      rsp_ff    <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         stack_mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= stack_mem[rd_addr];
   end

   rpncalc_alu u_alu (
      .clock   (clock),
      .reset   (reset),
      .alu_req (alu_req),
      .alu_rsp (alu_rsp)
   );

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_item   = rsp_ff;

   `RPN_ASSERT_NEXT(a_busy_after_accept, clock, reset, start && !busy, busy)
   `RPN_ASSERT_NOW(a_count_bounded, clock, reset, 1'b1, count_ff <= FULL_COUNT)
   `RPN_ASSERT_NEXT(a_halt_sticky, clock, reset, halted_ff, halted_ff)
   `RPN_ASSERT_NOW(a_strobe_when_idle, clock, reset, rsp_strobe, !busy)
   `RPN_ASSERT_NOW(a_div_zero_halts, clock, reset,
                   rsp_strobe && rsp_item.status == ST_DIV_ZERO, halted_ff)

endmodule
